@@ src/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       init;       // load IV, clear length
        logic       put;        // write byte into buffer
        logic [7:0] put_byte;
        logic       add_len;    // bump bit count by 8
        logic       latch_len;  // snapshot length for padding
        logic       start_cmp;  // load working vars from chain
        logic       round;      // run one round
        logic [5:0] round_idx;
        logic       finish_cmp; // add working vars into chain
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [5:0]  fill;
        logic [63:0] len;
    } t_dp_stat;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word ror32(input t_word x, input int unsigned r);
        ror32 = (x >> r) | (x << (32 - r));
    endfunction

endpackage

@@ src/sha_if.sv @@
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for input bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
    import sha_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface sha_out_if;
    import sha_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

@@ src/sha_datapath.sv @@
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, schedule, working variables, chain value and bit count.
// ----------------------------------------------------------------------------
module sha_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_dp_cmd  i_cmd,
    input  logic [2:0]        i_rd_idx,
    output logic [31:0]       o_rd_word,
    output sha_pkg::t_dp_stat o_stat
);
    import sha_pkg::*;

    // block buffer as 16 big-endian words, byte lanes written one at a time
    t_word       r_buf [16];
    t_word       r_w   [16];
    t_word       r_v   [8];
    t_word       r_h   [8];
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [63:0] r_len_snap;

    t_word w, s0, s1, t1, t2, ch, mj, a15, a2;
    logic [3:0] t4;

    always_comb begin
        t4  = i_cmd.round_idx[3:0];
        a15 = r_w[4'(t4 + 4'd1)];
        a2  = r_w[4'(t4 + 4'd14)];
        if (i_cmd.round_idx < 6'd16) begin
            w = r_buf[t4];
        end else begin
            w = r_w[t4]
              + (ror32(a15, 7) ^ ror32(a15, 18) ^ (a15 >> 3))
              + r_w[4'(t4 + 4'd9)]
              + (ror32(a2, 17) ^ ror32(a2, 19) ^ (a2 >> 10));
        end
        s1 = ror32(r_v[4], 6) ^ ror32(r_v[4], 11) ^ ror32(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + ROUND_K[i_cmd.round_idx] + w;
        s0 = ror32(r_v[0], 2) ^ ror32(r_v[0], 13) ^ ror32(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + mj;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            case (r_fill[1:0])
                2'd0: r_buf[r_fill[5:2]][31:24] <= i_cmd.put_byte;
                2'd1: r_buf[r_fill[5:2]][23:16] <= i_cmd.put_byte;
                2'd2: r_buf[r_fill[5:2]][15:8]  <= i_cmd.put_byte;
                default: r_buf[r_fill[5:2]][7:0] <= i_cmd.put_byte;
            endcase
        end
        if (i_cmd.latch_len) r_len_snap <= r_len;
        if (i_cmd.start_cmp) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end
        if (i_cmd.round) begin
            r_w[t4] <= w;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_HASH[i];
            r_fill <= '0;
            r_len  <= '0;
        end else begin
            if (i_cmd.put) r_fill <= r_fill + 6'd1;
            if (i_cmd.add_len) r_len <= r_len + 64'd8;
            if (i_cmd.finish_cmp) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_rd_word   = r_h[i_rd_idx];
    assign o_stat.fill = r_fill;
    assign o_stat.len  = r_len_snap;
endmodule

@@ src/sha_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, 64 rounds per block, digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha_in_if.sink            in_ch,
    sha_out_if.source         out_ch,
    input  sha_pkg::t_dp_stat i_stat,
    input  logic [31:0]       i_rd_word,
    output logic [2:0]        o_rd_idx,
    output sha_pkg::t_dp_cmd  o_cmd
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [5:0] r_round, n_round;
    logic       r_pad,   n_pad;     // finishing a message
    logic       r_zero,  n_zero;    // 0x80 already written
    logic       r_lenok, n_lenok;   // length slot of this block is live
    logic [2:0] r_widx,  n_widx;
    logic       r_ovld,  n_ovld;
    t_out_item  r_odata, n_odata;
    logic       acc;
    logic [5:0] fill_next;

    assign in_ch.ready  = (r_state == S_IDLE);
    assign acc          = in_ch.valid && in_ch.ready;
    assign out_ch.valid = r_ovld;
    assign out_ch.data  = r_odata;
    assign o_rd_idx     = r_widx;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_pad   = r_pad;
        n_zero  = r_zero;
        n_lenok = r_lenok;
        n_widx  = r_widx;
        n_ovld  = r_ovld;
        n_odata = r_odata;
        o_cmd   = '0;
        o_cmd.round_idx = r_round;
        fill_next = i_stat.fill + 6'd1;
        if (out_ch.valid && out_ch.ready) n_ovld = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_pad   = in_ch.data.last_byte;
                    n_zero  = 1'b0;
                    n_lenok = 1'b0;
                    if (in_ch.data.byte_valid) begin
                        o_cmd.put      = 1'b1;
                        o_cmd.put_byte = in_ch.data.data_byte;
                        o_cmd.add_len  = 1'b1;
                        if (fill_next == 6'd0) n_state = S_START;
                        else if (in_ch.data.last_byte) n_state = S_PAD;
                    end else if (in_ch.data.last_byte) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.put = 1'b1;
                if (!r_zero) begin
                    // length is snapped once, as the 0x80 pad byte is written
                    o_cmd.latch_len = 1'b1;
                    o_cmd.put_byte  = PAD_BYTE;
                    // 0x80 past the length slot pushes the length to the next block
                    n_lenok = (i_stat.fill < LEN_POS);
                end else if (i_stat.fill < LEN_POS || !r_lenok) begin
                    o_cmd.put_byte = 8'd0;
                end else begin
                    o_cmd.put_byte = i_stat.len[8*(7-i_stat.fill[2:0]) +: 8];
                end
                n_zero = 1'b1;
                if (fill_next == 6'd0) n_state = S_START;
            end
            S_START: begin
                o_cmd.start_cmp = 1'b1;
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) n_state = S_FIN;
            end
            S_FIN: begin
                // fold working vars into the chain after the last round
                o_cmd.finish_cmp = 1'b1;
                n_widx = '0;
                if (!r_pad) n_state = S_IDLE;
                else if (r_zero && r_lenok) n_state = S_EMIT;
                else begin
                    n_lenok = r_zero;
                    n_state = S_PAD;
                end
            end
            S_EMIT: begin
                if (!r_ovld || (out_ch.valid && out_ch.ready)) begin
                    n_ovld = 1'b1;
                    n_odata.digest_word = i_rd_word;
                    n_odata.word_index  = r_widx;
                    n_odata.last_word   = (r_widx == 3'd7);
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // last word in the output register; restart chain for next message
                o_cmd.init = 1'b1;
                n_pad   = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pad   <= 1'b0;
            r_zero  <= 1'b0;
            r_lenok <= 1'b0;
            r_ovld  <= 1'b0;
            r_widx  <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_pad   <= n_pad;
            r_zero  <= n_zero;
            r_lenok <= n_lenok;
            r_ovld  <= n_ovld;
            r_widx  <= n_widx;
            r_round <= n_round;
        end
        r_odata <= n_odata;
    end
endmodule

@@ src/sha256_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 over a byte stream; digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// A byte that does not fill a block is only written to the buffer; a full block
//   adds a load step, 64 rounds and a fold step. On end of message, padding
//   writes one pad byte at a time and runs load, rounds and fold for each
//   padding block, then makes 8 word transfers and a restart step.
// Throughput: one byte per cycle, only while the sequencer is idle.
// Reset (i_rst_n low, synchronous): chain value to the initial hash, counts clear.
module sha256_stream_hasher_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    import sha_pkg::*;

    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic [2:0]  rd_idx;
    logic [31:0] rd_word;

    // sequencer
    sha_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .i_stat    (stat),
        .i_rd_word (rd_word),
        .o_rd_idx  (rd_idx),
        .o_cmd     (cmd)
    );

    // storage and round logic
    sha_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_rd_idx  (rd_idx),
        .o_rd_word (rd_word),
        .o_stat    (stat)
    );
endmodule
